// File: hdl/cbg_pkg.sv
// Shared types and constants of the cell bucket group table.
package cbg_pkg;

  // Operation codes carried in the input tuser field.
  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_LOAD       = 3'd1,
    OP_CELL_LOOK  = 3'd2,
    OP_SLOT_LOOK  = 3'd3,
    OP_SIZE_QUERY = 3'd4
  } op_e;

  // Result status codes carried in the output tuser field.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_GROUP  = 2'd1,
    ST_FULL       = 2'd2,
    ST_NOT_LOADED = 2'd3
  } status_e;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_CELL_COUNT  = 3'd0;
  localparam logic [2:0] ADDR_GROUP_COUNT = 3'd4;

  localparam logic [7:0] CELL_COUNT_RST  = 8'd81;
  localparam logic [5:0] GROUP_COUNT_RST = 6'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_in;        // transfer accepted: latch request, read all stores
    logic rd_home_fill; // re-read the fill count of the cell's home group
    logic commit;       // update state and load the result register
  } cbg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_cell_look; // incoming operation is a cell lookup
    logic out_free;     // result register can take a new result this cycle
  } cbg_stat_t;

endpackage

// File: hdl/cbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cbg_ctrl.sv
// Sequencing state machine of the cell bucket group table.
module cbg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cbg_pkg::cbg_stat_t stat_i,
  output cbg_pkg::cbg_cmd_t  cmd_o
);
  import cbg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.in_cell_look ? S_LOOK : S_EXEC;
        end
      end
      S_LOOK: state_d = S_EXEC;
      S_EXEC: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign cmd_o.rd_in        = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.rd_home_fill = (state_q == S_LOOK);
  assign cmd_o.commit       = (state_q == S_EXEC) && stat_i.out_free;

endmodule

// File: hdl/cbg_dp.sv
// Datapath of the cell bucket group table: stores, counters and result register.
module cbg_dp #(
  parameter int MAX_CELLS      = 128,
  parameter int MAX_GROUPS     = 32,
  parameter int MAX_GROUP_SIZE = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbg_pkg::cbg_cmd_t  cmd_i,
  output cbg_pkg::cbg_stat_t stat_o,
  input  logic [7:0]         cell_count_i,
  input  logic [5:0]         group_count_i,
  input  logic [2:0]         in_op_i,
  input  logic [4:0]         in_group_i,
  input  logic [6:0]         in_pos_i,
  input  logic [4:0]         in_slot_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_status_o,
  output logic [4:0]         out_group_o,
  output logic [4:0]         out_slot_o,
  output logic [7:0]         out_cell_o,
  output logic [5:0]         out_size_o,
  output logic [5:0]         out_largest_o
);
  import cbg_pkg::*;

  localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SW    = (MAX_GROUP_SIZE > 1) ? $clog2(MAX_GROUP_SIZE) : 1;
  localparam int FW    = $clog2(MAX_GROUP_SIZE + 1);
  localparam int CIW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int LW    = $clog2(MAX_CELLS + 1);
  localparam int SLOTS = MAX_GROUPS * MAX_GROUP_SIZE;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Request held while it is worked on.
  op_e        req_op_q;
  logic [4:0] req_group_q;
  logic [6:0] req_pos_q;
  logic [4:0] req_slot_q;

  // Table state.
  logic [LW-1:0]         loaded_q, loaded_d;
  logic [FW-1:0]         largest_q, largest_d;
  logic [MAX_GROUPS-1:0] fill_vld_q, fill_vld_d;
  logic                  fill_rd_vld_q;

  // Result register.
  logic       out_valid_q;
  logic [1:0] out_status_q, out_status_d;
  logic [4:0] out_group_q, out_group_d;
  logic [4:0] out_slot_q, out_slot_d;
  logic [7:0] out_cell_q, out_cell_d;
  logic [5:0] out_size_q, out_size_d;

  // Store ports.
  logic [GIW-1:0]    fill_raddr;
  logic [FW-1:0]     fill_rdata;
  logic              fill_we;
  logic [FW-1:0]     fill_wdata;
  logic [GIW+SW-1:0] home_rdata;
  logic              home_we;
  logic [AW-1:0]     slot_raddr, slot_waddr;
  logic [CIW-1:0]    slot_rdata;
  logic              slot_we;

  logic [GIW-1:0] home_group;
  logic [SW-1:0]  home_slot;
  logic [FW-1:0]  fill_cur, fill_new;
  logic           group_ok;
  logic           load_good;

  assign stat_o.in_cell_look = (in_op_i == OP_CELL_LOOK);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign home_group = home_rdata[GIW+SW-1:SW];
  assign home_slot  = home_rdata[SW-1:0];

  // Read the home group's fill for a cell lookup, else the requested group's.
  assign fill_raddr = cmd_i.rd_home_fill ? home_group : GIW'(in_group_i);
  assign slot_raddr = AW'(32'(in_group_i) * MAX_GROUP_SIZE + 32'(in_slot_i));
  assign slot_waddr = AW'(32'(req_group_q) * MAX_GROUP_SIZE + 32'(fill_cur));

  // A group not written since the last clear reads as empty.
  assign fill_cur = fill_rd_vld_q ? fill_rdata : '0;
  assign fill_new = fill_cur + FW'(1);

  assign group_ok = (32'(req_group_q) < 32'(group_count_i)) &&
                    (32'(req_group_q) < MAX_GROUPS);

  assign load_good = (req_op_q == OP_LOAD) && group_ok &&
                     (32'(loaded_q) < 32'(cell_count_i)) &&
                     (32'(loaded_q) < MAX_CELLS) &&
                     (32'(fill_cur) < MAX_GROUP_SIZE);

  assign fill_we    = cmd_i.commit && load_good;
  assign fill_wdata = fill_new;
  assign home_we    = cmd_i.commit && load_good;
  assign slot_we    = cmd_i.commit && load_good;

  cbg_ram #(.WIDTH(FW), .DEPTH(MAX_GROUPS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (GIW'(req_group_q)),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.rd_in || cmd_i.rd_home_fill),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  cbg_ram #(.WIDTH(GIW + SW), .DEPTH(MAX_CELLS)) u_home_ram (
    .clk_i   (clk_i),
    .we_i    (home_we),
    .waddr_i (loaded_q[CIW-1:0]),
    .wdata_i ({GIW'(req_group_q), fill_cur[SW-1:0]}),
    .re_i    (cmd_i.rd_in),
    .raddr_i (CIW'(in_pos_i)),
    .rdata_o (home_rdata)
  );

  cbg_ram #(.WIDTH(CIW), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (loaded_q[CIW-1:0]),
    .re_i    (cmd_i.rd_in),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // Work out the next table state and the result of the held request.
  always_comb begin
    loaded_d     = loaded_q;
    largest_d    = largest_q;
    fill_vld_d   = fill_vld_q;
    out_status_d = ST_OK;
    out_group_d  = '0;
    out_slot_d   = '0;
    out_cell_d   = '0;
    out_size_d   = '0;
    unique case (req_op_q)
      OP_CLEAR: begin
        loaded_d   = '0;
        largest_d  = '0;
        fill_vld_d = '0;
      end
      OP_LOAD: begin
        if (!group_ok) begin
          out_status_d = ST_BAD_GROUP;
        end else if (!load_good) begin
          out_status_d = ST_FULL;
        end else begin
          fill_vld_d[GIW'(req_group_q)] = 1'b1;
          if (fill_new > largest_q) begin
            largest_d = fill_new;
          end
          loaded_d    = loaded_q + LW'(1);
          out_group_d = req_group_q;
          out_slot_d  = 5'(fill_cur);
          out_cell_d  = 8'(loaded_q);
          out_size_d  = 6'(fill_new);
        end
      end
      OP_CELL_LOOK: begin
        if ((32'(req_pos_q) >= 32'(loaded_q)) || (32'(req_pos_q) >= MAX_CELLS)) begin
          out_status_d = ST_NOT_LOADED;
        end else begin
          out_group_d = 5'(home_group);
          out_slot_d  = 5'(home_slot);
          out_cell_d  = 8'(req_pos_q);
          out_size_d  = 6'(fill_cur);
        end
      end
      OP_SLOT_LOOK: begin
        if (!group_ok) begin
          out_status_d = ST_BAD_GROUP;
        end else begin
          out_group_d = req_group_q;
          out_slot_d  = req_slot_q;
          out_size_d  = 6'(fill_cur);
          out_cell_d  = (32'(req_slot_q) >= 32'(fill_cur)) ? cell_count_i
                                                          : 8'(slot_rdata);
        end
      end
      OP_SIZE_QUERY: begin
        if (!group_ok) begin
          out_status_d = ST_BAD_GROUP;
        end else begin
          out_group_d = req_group_q;
          out_size_d  = 6'(fill_cur);
        end
      end
      default: begin
      end
    endcase
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_in) begin
      req_op_q    <= op_e'(in_op_i);
      req_group_q <= in_group_i;
      req_pos_q   <= in_pos_i;
      req_slot_q  <= in_slot_i;
    end
    if (cmd_i.commit) begin
      out_status_q <= out_status_d;
      out_group_q  <= out_group_d;
      out_slot_q   <= out_slot_d;
      out_cell_q   <= out_cell_d;
      out_size_q   <= out_size_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q      <= '0;
      largest_q     <= '0;
      fill_vld_q    <= '0;
      fill_rd_vld_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        loaded_q   <= loaded_d;
        largest_q  <= largest_d;
        fill_vld_q <= fill_vld_d;
      end
      if (cmd_i.rd_in || cmd_i.rd_home_fill) begin
        fill_rd_vld_q <= fill_vld_q[fill_raddr];
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_group_o   = out_group_q;
  assign out_slot_o    = out_slot_q;
  assign out_cell_o    = out_cell_q;
  assign out_size_o    = out_size_q;
  assign out_largest_o = 6'(largest_q);

endmodule

// File: hdl/cell_bucket_group_table.sv
// Top level of the cell bucket group table: stream ports, register port, core.
//
// Cells are loaded in ascending order, each naming its group; the block
// appends the cell to the next free slot of that group, keeps a fill count
// per group and the largest fill, and records each cell's group and slot.
// Requests arrive on the slave stream (operation in tuser: clear, load,
// cell lookup, slot lookup, size query) and every request gives exactly one
// result on the master stream. The stores are read at the transfer edge;
// the execute step then updates them and registers the result, waiting
// there while the result register holds a result not yet taken. A cell
// lookup passes through a home step before the execute step, because the
// fill count of the cell's home group is read only once the home entry is
// known. One item is worked on at a time; the result register lets the next
// request be taken while a result waits, and a stalled result holds the core
// in its final step. Reading a slot that is unused returns cell_count as
// found_cell. cell_count (0x0) and group_count (0x4) are written through the
// APB port; the user must write them only while the block is idle, which
// the block itself does not enforce; they take effect for later requests.
// largest_size on the output follows the table at all times and is the
// value after the request whose result is shown.
module cell_bucket_group_table #(
  parameter int MAX_CELLS      = 128,
  parameter int MAX_GROUPS     = 32,
  parameter int MAX_GROUP_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // group_id[4:0], cell_position[11:5], slot_index[16:12]
  input  logic [2:0]  s_axis_tuser,  // operation[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // found_group[4:0], found_slot[9:5], found_cell[17:10],
                                     // group_size[23:18], largest_size[29:24]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import cbg_pkg::*;

  logic [7:0] cell_count_q;
  logic [5:0] group_count_q;
  logic       cfg_wr;

  cbg_cmd_t  cmd;
  cbg_stat_t stat;

  logic [1:0] out_status;
  logic [4:0] out_group, out_slot;
  logic [7:0] out_cell;
  logic [5:0] out_size, out_largest;

  // Register port: write on the access cycle, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q  <= CELL_COUNT_RST;
      group_count_q <= GROUP_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr == ADDR_CELL_COUNT) begin
        cell_count_q <= pwdata[7:0];
      end
      if (paddr == ADDR_GROUP_COUNT) begin
        group_count_q <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CELL_COUNT) begin
      prdata = 32'(cell_count_q);
    end else if (paddr == ADDR_GROUP_COUNT) begin
      prdata = 32'(group_count_q);
    end
  end

  cbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbg_dp #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_GROUPS     (MAX_GROUPS),
    .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cell_count_i   (cell_count_q),
    .group_count_i  (group_count_q),
    .in_op_i        (s_axis_tuser),
    .in_group_i     (s_axis_tdata[4:0]),
    .in_pos_i       (s_axis_tdata[11:5]),
    .in_slot_i      (s_axis_tdata[16:12]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (out_status),
    .out_group_o    (out_group),
    .out_slot_o     (out_slot),
    .out_cell_o     (out_cell),
    .out_size_o     (out_size),
    .out_largest_o  (out_largest)
  );

  // Pack the result; the upper bits pad to whole bytes.
  assign m_axis_tdata = {2'b00, out_largest, out_size, out_cell, out_slot, out_group};
  assign m_axis_tuser = out_status;

endmodule

// File: tb/cbg_table_checker.sv
// Checker for the cell bucket group table: predicts every result and compares it on transfer.
module cbg_table_checker #(
  parameter int MAX_CELLS      = 128,
  parameter int MAX_GROUPS     = 32,
  parameter int MAX_GROUP_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // group_id[4:0], cell_position[11:5], slot_index[16:12]
  input  logic [2:0]  s_axis_tuser,  // operation[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // found_group[4:0], found_slot[9:5], found_cell[17:10],
                                     // group_size[23:18], largest_size[29:24]
  input  logic [1:0]  m_axis_tuser,  // status[1:0]
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbg_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [4:0] grp;
    logic [4:0] slot;
    logic [7:0] cell_no;
    logic [5:0] size;
    logic [5:0] largest;
  } table_result_t;

  // Shadow copy of the registers and the table.
  logic [7:0] cell_count_q;
  logic [5:0] group_count_q;
  int         loaded_cells;
  int         largest_fill;
  int         group_fill [MAX_GROUPS];
  int         home_group [MAX_CELLS];
  int         home_slot  [MAX_CELLS];
  int         slot_cell  [MAX_GROUPS*MAX_GROUP_SIZE];

  table_result_t expected_results[$];
  int            fail_count;
  int            checked;

  function automatic bit group_valid(logic [4:0] g);
    return (int'(g) < int'(group_count_q)) && (int'(g) < MAX_GROUPS);
  endfunction

  // Apply one request to the shadow table and return the result it causes.
  function automatic table_result_t apply_request(logic [2:0] op, logic [4:0] g,
                                                  logic [6:0] pos, logic [4:0] slot);
    table_result_t r;
    int            c;
    int            s;
    int            hg;
    r = '0;
    case (op)
      OP_CLEAR: begin
        loaded_cells = 0;
        largest_fill = 0;
        foreach (group_fill[i]) group_fill[i] = 0;
      end
      OP_LOAD: begin
        if (!group_valid(g)) begin
          r.status = ST_BAD_GROUP;
        end else if (loaded_cells >= int'(cell_count_q) || loaded_cells >= MAX_CELLS ||
                     group_fill[g] >= MAX_GROUP_SIZE) begin
          r.status = ST_FULL;
        end else begin
          c = loaded_cells;
          s = group_fill[g];
          slot_cell[int'(g)*MAX_GROUP_SIZE + s] = c;
          home_group[c] = int'(g);
          home_slot[c]  = s;
          group_fill[g] = s + 1;
          if (group_fill[g] > largest_fill) largest_fill = group_fill[g];
          loaded_cells = c + 1;
          r.grp     = g;
          r.slot    = 5'(s);
          r.cell_no = 8'(c);
          r.size    = 6'(group_fill[g]);
        end
      end
      OP_CELL_LOOK: begin
        if (int'(pos) >= loaded_cells || int'(pos) >= MAX_CELLS) begin
          r.status = ST_NOT_LOADED;
        end else begin
          hg        = home_group[pos];
          r.grp     = 5'(hg);
          r.slot    = 5'(home_slot[pos]);
          r.cell_no = 8'(pos);
          r.size    = (hg < MAX_GROUPS) ? 6'(group_fill[hg]) : 6'd0;
        end
      end
      OP_SLOT_LOOK: begin
        if (!group_valid(g)) begin
          r.status = ST_BAD_GROUP;
        end else begin
          r.grp  = g;
          r.slot = slot;
          r.size = 6'(group_fill[g]);
          // an unused slot answers with the cell count
          if (int'(slot) >= group_fill[g] || int'(slot) >= MAX_GROUP_SIZE)
            r.cell_no = cell_count_q;
          else
            r.cell_no = 8'(slot_cell[int'(g)*MAX_GROUP_SIZE + int'(slot)]);
        end
      end
      OP_SIZE_QUERY: begin
        if (!group_valid(g)) begin
          r.status = ST_BAD_GROUP;
        end else begin
          r.grp  = g;
          r.size = 6'(group_fill[g]);
        end
      end
      default: ;
    endcase
    r.largest = 6'(largest_fill);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                checked, name, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      cell_count_q  = CELL_COUNT_RST;
      group_count_q = GROUP_COUNT_RST;
      loaded_cells  = 0;
      largest_fill  = 0;
      foreach (group_fill[i]) group_fill[i] = 0;
      expected_results.delete();
      fail_count    = 0;
      checked       = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_CELL_COUNT:  cell_count_q  = pwdata[7:0];
          ADDR_GROUP_COUNT: group_count_q = pwdata[5:0];
          default: ;
        endcase
      end
      // compare before queuing, so a stray result is never matched to a new request
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tdata[17:10],
               m_axis_tdata[23:18], m_axis_tdata[29:24]};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending (tdata %h)",
                                    checked, m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 8'(want.status), 8'(got.status));
          check_field("found_group", 8'(want.grp), 8'(got.grp));
          check_field("found_slot", 8'(want.slot), 8'(got.slot));
          check_field("found_cell", want.cell_no, got.cell_no);
          check_field("group_size", 8'(want.size), 8'(got.size));
          check_field("largest_size", 8'(want.largest), 8'(got.largest));
          check_field("tdata padding", 8'd0, 8'(m_axis_tdata[31:30]));
        end
        checked++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(),
                                apply_request(s_axis_tuser, s_axis_tdata[4:0],
                                              s_axis_tdata[11:5], s_axis_tdata[16:12]));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
  end

endmodule

// File: tb/cell_bucket_group_table_tb.sv
// Top of the testbench: clock, reset, stimulus on both streams and the register port, verdict.
module cell_bucket_group_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbg_pkg::*;

  // Operation codes outside the defined set; the block must treat them as no-ops.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 250;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // group_id[4:0], cell_position[11:5], slot_index[16:12]
  logic [2:0]  s_axis_tuser;   // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // found_group[4:0], found_slot[9:5], found_cell[17:10],
                               // group_size[23:18], largest_size[29:24]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  int fail_count;
  int pending_results;
  int checked_results;
  int cycle_count;
  int requests_sent;
  int settings_used;
  int est_loaded;   // rough count of loads since the last clear, used only to aim lookups

  cell_bucket_group_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cbg_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results),
    .checked_o     (checked_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs; the limit is far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: draw a stall before every transfer, keep some stretches without
  // stalls, and twice hold off for a long stretch so the block backs up into its input.
  initial begin
    int rx_count;
    int gap;
    rx_count = 0;
    gap = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        rx_count++;
        if (rx_count == 80 || rx_count == 330)
          gap = LONG_HOLD;
        else if (((rx_count / 64) % 3) == 2)
          gap = 0;
        else
          gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request after a drawn gap and hold it until the transfer.
  // Drop tvalid only when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(logic [2:0] op, logic [4:0] g, logic [6:0] pos,
                              logic [4:0] slot);
    int gap;
    gap = (((requests_sent / 50) % 3) == 1) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, slot, pos, g};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (op == OP_LOAD && est_loaded < 128) est_loaded++;
    if (op == OP_CLEAR) est_loaded = 0;
  endtask

  // Drop the request stream and wait until every expected result has arrived.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle held until pready.
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int         phase;
    int         item;
    int         cc;
    int         gc;
    int         load_pct;
    int         span;
    int         reach;
    bit         clear_first;
    bit         clears_ok;
    int         n_items;
    int         r;
    logic [2:0] op;
    logic [4:0] g;
    logic [6:0] pos;
    logic [4:0] slot;

    requests_sent = 0;
    settings_used = 1;
    est_loaded    = 0;
    cycle_count   = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CLEAR;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values (81 cells, 9 groups).
    send_request(OP_SIZE_QUERY, 5'd0, 7'd127, 5'd31);   // empty group
    send_request(OP_SLOT_LOOK, 5'd0, 7'd0, 5'd0);       // unused slot gives the sentinel
    send_request(OP_CELL_LOOK, 5'd31, 7'd0, 5'd0);      // nothing loaded yet
    send_request(OP_LOAD, 5'd31, 7'd127, 5'd31);        // id far above the group limit
    send_request(OP_LOAD, 5'd9, 7'd0, 5'd0);            // id just at the group limit
    send_request(OP_LOAD, 5'd0, 7'd0, 5'd0);
    send_request(OP_LOAD, 5'd8, 7'd127, 5'd31);
    send_request(OP_LOAD, 5'd0, 7'd64, 5'd16);
    send_request(OP_CELL_LOOK, 5'd0, 7'd0, 5'd0);
    send_request(OP_CELL_LOOK, 5'd31, 7'd2, 5'd31);
    send_request(OP_CELL_LOOK, 5'd0, 7'd3, 5'd0);       // just past the loaded cells
    send_request(OP_CELL_LOOK, 5'd0, 7'd127, 5'd0);
    send_request(OP_SLOT_LOOK, 5'd0, 7'd0, 5'd1);
    send_request(OP_SLOT_LOOK, 5'd0, 7'd127, 5'd31);    // far beyond the fill
    send_request(OP_SLOT_LOOK, 5'd8, 7'd0, 5'd1);       // just at the fill
    send_request(OP_SLOT_LOOK, 5'd20, 7'd0, 5'd0);      // bad group
    send_request(OP_SIZE_QUERY, 5'd8, 7'd0, 5'd0);
    send_request(OP_SIZE_QUERY, 5'd31, 7'd0, 5'd0);     // bad group
    send_request(OP_UNUSED_LO, 5'd31, 7'd127, 5'd31);
    send_request(OP_UNUSED_HI, 5'd0, 7'd0, 5'd0);
    send_request(OP_CLEAR, 5'd31, 7'd127, 5'd31);
    send_request(OP_CELL_LOOK, 5'd0, 7'd0, 5'd0);       // cleared table forgets every cell
    send_request(OP_SIZE_QUERY, 5'd0, 7'd0, 5'd0);
    send_request(OP_LOAD, 5'd8, 7'd0, 5'd0);            // numbering restarts at zero
    send_request(OP_CELL_LOOK, 5'd0, 7'd0, 5'd0);

    // Random phases. The first three are fixed: fill the whole table, fill one
    // group, then shrink the limits over loaded data without clearing.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          cc = 128; gc = 32; load_pct = 85; span = 32;
          clear_first = 1'b1; clears_ok = 1'b0; n_items = 170;
        end
        1: begin
          cc = 128; gc = 1; load_pct = 70; span = 1;
          clear_first = 1'b1; clears_ok = 1'b0; n_items = 70;
        end
        2: begin
          cc = 1; gc = 32; load_pct = 40; span = 32;
          clear_first = 1'b0; clears_ok = 1'b0; n_items = 50;
        end
        default: begin
          cc = $urandom_range(1, 128); gc = $urandom_range(1, 32);
          load_pct = 50; span = $urandom_range(2, 32);
          clear_first = 1'($urandom_range(0, 1)); clears_ok = 1'b1; n_items = 72;
        end
      endcase

      // Reprogram only while the block is idle.
      wait_idle();
      apb_write(ADDR_CELL_COUNT, {24'd0, 8'(cc)});
      apb_write(ADDR_GROUP_COUNT, {26'd0, 6'(gc)});
      settings_used++;
      if (clear_first)
        send_request(OP_CLEAR, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                     5'($urandom_range(0, 31)));

      reach = (gc < span) ? gc : span;
      for (item = 0; item < n_items; item++) begin
        // Aim mostly at valid groups, with some ids anywhere in the field.
        if ($urandom_range(0, 99) < 85)
          g = 5'($urandom_range(0, reach - 1));
        else
          g = 5'($urandom_range(0, 31));
        if (est_loaded > 0 && $urandom_range(0, 99) < 70)
          pos = 7'($urandom_range(0, est_loaded - 1));
        else
          pos = 7'($urandom_range(0, 127));
        slot = $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));

        if ($urandom_range(0, 99) < load_pct) begin
          op = OP_LOAD;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 36)
            op = OP_CELL_LOOK;
          else if (r < 72)
            op = OP_SLOT_LOOK;
          else if (r < 92)
            op = OP_SIZE_QUERY;
          else if (r < 96 && clears_ok)
            op = OP_CLEAR;
          else if (r < 96)
            op = OP_SIZE_QUERY;
          else
            op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        send_request(op, g, pos, slot);
      end
    end

    // Drain, then keep the clock running so that any stray result still shows.
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked results over %0d register settings.",
             requests_sent, checked_results, settings_used);
    $display("Phases filled the whole table and a single group, and shrank limits over loaded data.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending_results);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cbg_pkg.sv
hdl/cbg_ram.sv
hdl/cbg_ctrl.sv
hdl/cbg_dp.sv
hdl/cell_bucket_group_table.sv
tb/cbg_table_checker.sv
tb/cell_bucket_group_table_tb.sv
